@@ hdl/mqdh_pkg.sv @@
// Package for the multiqueue d-ary heap scheduler.
// Types, sizes and codes shared by the front, back and top level.
package mqdh_pkg;
	localparam int NUM_HEAPS     = 16;
	localparam int HEAP_CAPACITY = 128;
	localparam int ARITY         = 8;
	localparam int HW            = $clog2(NUM_HEAPS);
	localparam int POS_W         = $clog2(HEAP_CAPACITY);
	localparam int FW            = $clog2(HEAP_CAPACITY + 1);
	localparam int CW            = POS_W + $clog2(ARITY) + 1;
	localparam int AW            = HW + POS_W;
	localparam int CFG_W         = 5;
	localparam int QDEPTH        = 2;
	localparam logic signed [15:0] EMPTY_PRIO = 16'sh7FFF;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_QUERY  = 2'd2;
	localparam logic [1:0] FN_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [2:0] REG_HEAP_COUNT = 3'd0;

	typedef enum logic [2:0] {K_INS, K_DEL, K_QRY, K_NOP, K_ERR} kind_t;

	typedef struct packed {
		logic [15:0]        handle;
		logic signed [15:0] prio;
	} slot_t;

	typedef struct packed {
		kind_t              kind;
		logic [HW-1:0]      ha;
		logic [HW-1:0]      hb;
		logic [15:0]        handle;
		logic signed [15:0] prio;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TOPA, S_TOPB, S_DSEL, S_DROOT, S_DLAST, S_DCHK, S_DCHILD,
		S_DDEC, S_INS, S_UCHK, S_UWAIT, S_DONE
	} state_t;
endpackage

@@ hdl/mqdh_front.sv @@
// Front end: accepts words, checks heap indices, queues decoded commands.
// Depends on mqdh_pkg.
module mqdh_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mqdh_pkg::CFG_W-1:0] heap_count,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [mqdh_pkg::HW-1:0]    heap_a,
	input  logic [mqdh_pkg::HW-1:0]    heap_b,
	input  logic [15:0]                task_handle,
	input  logic signed [15:0]         priority_req,
	output logic                       cmd_valid,
	output mqdh_pkg::cmd_t             cmd,
	input  logic                       cmd_pop
);
	mqdh_pkg::cmd_t  q_q [mqdh_pkg::QDEPTH];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	mqdh_pkg::cmd_t  dec;
	logic            ok_a, ok_b, push;

	assign ok_a = (mqdh_pkg::CFG_W'(heap_a) < heap_count);
	assign ok_b = (mqdh_pkg::CFG_W'(heap_b) < heap_count);

	always_comb begin
		dec.ha     = heap_a;
		dec.hb     = heap_b;
		dec.handle = task_handle;
		dec.prio   = priority_req;
		case (func)
			mqdh_pkg::FN_INSERT: dec.kind = ok_a ? mqdh_pkg::K_INS : mqdh_pkg::K_ERR;
			mqdh_pkg::FN_DELETE: dec.kind = (ok_a && ok_b) ? mqdh_pkg::K_DEL : mqdh_pkg::K_ERR;
			mqdh_pkg::FN_QUERY:  dec.kind = (ok_a && ok_b) ? mqdh_pkg::K_QRY : mqdh_pkg::K_ERR;
			default:             dec.kind = mqdh_pkg::K_NOP;
		endcase
	end

	assign in_stall  = (cnt_q == 2'(mqdh_pkg::QDEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (cmd_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

@@ hdl/mqdh_back.sv @@
// Back end: heap engine with slot memory, fill counts, cached tops, result register.
// Depends on mqdh_pkg.
module mqdh_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  mqdh_pkg::cmd_t        cmd,
	output logic                  cmd_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [15:0]           out_task,
	output logic signed [15:0]    out_priority
);
	localparam int DEPTH = mqdh_pkg::NUM_HEAPS * mqdh_pkg::HEAP_CAPACITY;

	mqdh_pkg::slot_t mem_q [DEPTH];
	mqdh_pkg::slot_t rdata_q;

	logic [mqdh_pkg::FW-1:0]   fill_q [mqdh_pkg::NUM_HEAPS];
	logic signed [15:0]        top_q  [mqdh_pkg::NUM_HEAPS];

	mqdh_pkg::state_t          state_q, state_d;
	mqdh_pkg::cmd_t            cmd_q;
	logic [mqdh_pkg::HW-1:0]   h_q;
	logic signed [15:0]        ta_q;
	logic [mqdh_pkg::POS_W-1:0] hole_q, n_q, ri_q, bidx_q;
	logic [mqdh_pkg::FW-1:0]   ci_q, last_q;
	mqdh_pkg::slot_t           x_q, best_q;
	logic                      found_q;
	logic [1:0]                rs_q;
	logic [15:0]               rt_q;
	logic signed [15:0]        rp_q;

	logic                      we, re;
	logic [mqdh_pkg::POS_W-1:0] wpos, rpos;
	mqdh_pkg::slot_t           wdata;
	logic [mqdh_pkg::FW-1:0]   fill_rd;
	logic signed [15:0]        top_rd;
	logic [mqdh_pkg::CW-1:0]   first_w, lastc_w;
	logic [mqdh_pkg::POS_W-1:0] parent;
	logic                      load_out, swap_up, take_b, stop_dn, more;

	assign fill_rd = fill_q[h_q];
	assign top_rd  = top_q[h_q];
	assign first_w = mqdh_pkg::CW'(hole_q) * mqdh_pkg::CW'(mqdh_pkg::ARITY) + mqdh_pkg::CW'(1);
	assign lastc_w = first_w + mqdh_pkg::CW'(mqdh_pkg::ARITY - 1);
	assign parent  = mqdh_pkg::POS_W'((hole_q - mqdh_pkg::POS_W'(1)) / mqdh_pkg::ARITY);
	assign swap_up = (x_q.prio <= rdata_q.prio);
	assign take_b  = (ta_q > top_rd);
	assign stop_dn = (best_q.prio > x_q.prio);
	assign more    = (ci_q <= last_q);
	assign load_out = (state_q == mqdh_pkg::S_DONE) && (!out_valid || !out_stall);
	assign cmd_pop  = (state_q == mqdh_pkg::S_IDLE) && cmd_valid;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		re      = 1'b0;
		wpos    = hole_q;
		rpos    = '0;
		wdata   = x_q;
		case (state_q)
			mqdh_pkg::S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						mqdh_pkg::K_INS: state_d = mqdh_pkg::S_INS;
						mqdh_pkg::K_DEL,
						mqdh_pkg::K_QRY: state_d = mqdh_pkg::S_TOPA;
						default:         state_d = mqdh_pkg::S_DONE;
					endcase
				end
			end
			mqdh_pkg::S_TOPA: state_d = mqdh_pkg::S_TOPB;
			mqdh_pkg::S_TOPB: begin
				if (cmd_q.kind == mqdh_pkg::K_QRY) begin
					state_d = mqdh_pkg::S_DONE;
				end else if ((take_b ? top_rd : ta_q) == mqdh_pkg::EMPTY_PRIO) begin
					state_d = mqdh_pkg::S_DONE;
				end else begin
					state_d = mqdh_pkg::S_DSEL;
				end
			end
			mqdh_pkg::S_DSEL: begin
				if (fill_rd == '0) begin
					state_d = mqdh_pkg::S_DONE;
				end else begin
					re      = 1'b1;
					rpos    = '0;
					state_d = mqdh_pkg::S_DROOT;
				end
			end
			mqdh_pkg::S_DROOT: begin
				if (n_q == '0) begin
					state_d = mqdh_pkg::S_DONE;
				end else begin
					re      = 1'b1;
					rpos    = n_q;
					state_d = mqdh_pkg::S_DLAST;
				end
			end
			mqdh_pkg::S_DLAST: state_d = mqdh_pkg::S_DCHK;
			mqdh_pkg::S_DCHK: begin
				if (first_w >= mqdh_pkg::CW'(n_q)) begin
					we      = 1'b1;
					state_d = mqdh_pkg::S_DONE;
				end else begin
					re      = 1'b1;
					rpos    = mqdh_pkg::POS_W'(first_w);
					state_d = mqdh_pkg::S_DCHILD;
				end
			end
			mqdh_pkg::S_DCHILD: begin
				if (more) begin
					re   = 1'b1;
					rpos = mqdh_pkg::POS_W'(ci_q);
				end else begin
					state_d = mqdh_pkg::S_DDEC;
				end
			end
			mqdh_pkg::S_DDEC: begin
				we = 1'b1;
				if (stop_dn) begin
					state_d = mqdh_pkg::S_DONE;
				end else begin
					wdata   = best_q;
					state_d = mqdh_pkg::S_DCHK;
				end
			end
			mqdh_pkg::S_INS: begin
				state_d = (fill_rd >= mqdh_pkg::FW'(mqdh_pkg::HEAP_CAPACITY)) ?
					mqdh_pkg::S_DONE : mqdh_pkg::S_UCHK;
			end
			mqdh_pkg::S_UCHK: begin
				if (hole_q == '0) begin
					we      = 1'b1;
					state_d = mqdh_pkg::S_DONE;
				end else begin
					re      = 1'b1;
					rpos    = parent;
					state_d = mqdh_pkg::S_UWAIT;
				end
			end
			mqdh_pkg::S_UWAIT: begin
				we = 1'b1;
				if (swap_up) begin
					wdata   = rdata_q;
					state_d = mqdh_pkg::S_UCHK;
				end else begin
					state_d = mqdh_pkg::S_DONE;
				end
			end
			mqdh_pkg::S_DONE: begin
				if (load_out) begin
					state_d = mqdh_pkg::S_IDLE;
				end
			end
			default: state_d = mqdh_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[{h_q, wpos}] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[{h_q, rpos}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqdh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// heap bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mqdh_pkg::NUM_HEAPS; i++) begin
				fill_q[i] <= '0;
				top_q[i]  <= mqdh_pkg::EMPTY_PRIO;
			end
		end else begin
			case (state_q)
				mqdh_pkg::S_INS: begin
					if (fill_rd < mqdh_pkg::FW'(mqdh_pkg::HEAP_CAPACITY)) begin
						fill_q[h_q] <= fill_rd + mqdh_pkg::FW'(1);
						if (cmd_q.prio < top_rd) begin
							top_q[h_q] <= cmd_q.prio;
						end
					end
				end
				mqdh_pkg::S_DSEL: begin
					if (fill_rd != '0) begin
						fill_q[h_q] <= fill_rd - mqdh_pkg::FW'(1);
					end
				end
				mqdh_pkg::S_DROOT: begin
					if (n_q == '0) begin
						top_q[h_q] <= mqdh_pkg::EMPTY_PRIO;
					end
				end
				mqdh_pkg::S_DCHK: begin
					if (first_w >= mqdh_pkg::CW'(n_q) && hole_q == '0) begin
						top_q[h_q] <= x_q.prio;
					end
				end
				mqdh_pkg::S_DDEC: begin
					if (hole_q == '0) begin
						top_q[h_q] <= stop_dn ? x_q.prio : best_q.prio;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mqdh_pkg::S_IDLE: begin
				cmd_q <= cmd;
				h_q   <= cmd.ha;
				x_q   <= '{handle: cmd.handle, prio: cmd.prio};
				rs_q  <= (cmd.kind == mqdh_pkg::K_ERR) ? mqdh_pkg::ST_RANGE : mqdh_pkg::ST_OK;
				rt_q  <= '0;
				rp_q  <= '0;
			end
			mqdh_pkg::S_TOPA: begin
				ta_q <= top_rd;
				h_q  <= cmd_q.hb;
			end
			mqdh_pkg::S_TOPB: begin
				if (cmd_q.kind == mqdh_pkg::K_QRY) begin
					rp_q <= take_b ? top_rd : ta_q;
				end else begin
					if (!take_b) begin
						h_q <= cmd_q.ha;
					end
					if ((take_b ? top_rd : ta_q) == mqdh_pkg::EMPTY_PRIO) begin
						rs_q <= mqdh_pkg::ST_EMPTY;
						rp_q <= mqdh_pkg::EMPTY_PRIO;
					end
				end
			end
			mqdh_pkg::S_DSEL: begin
				n_q <= mqdh_pkg::POS_W'(fill_rd - mqdh_pkg::FW'(1));
				if (fill_rd == '0) begin
					rs_q <= mqdh_pkg::ST_EMPTY;
					rp_q <= mqdh_pkg::EMPTY_PRIO;
				end
			end
			mqdh_pkg::S_DROOT: begin
				rt_q <= rdata_q.handle;
				rp_q <= rdata_q.prio;
			end
			mqdh_pkg::S_DLAST: begin
				x_q    <= rdata_q;
				hole_q <= '0;
			end
			mqdh_pkg::S_DCHK: begin
				found_q <= 1'b0;
				ri_q    <= mqdh_pkg::POS_W'(first_w);
				ci_q    <= mqdh_pkg::FW'(first_w + mqdh_pkg::CW'(1));
				last_q  <= (lastc_w < mqdh_pkg::CW'(n_q)) ? mqdh_pkg::FW'(lastc_w) :
					mqdh_pkg::FW'(n_q - mqdh_pkg::POS_W'(1));
			end
			mqdh_pkg::S_DCHILD: begin
				if (!found_q || rdata_q.prio <= best_q.prio) begin
					best_q <= rdata_q;
					bidx_q <= ri_q;
				end
				found_q <= 1'b1;
				if (more) begin
					ri_q <= mqdh_pkg::POS_W'(ci_q);
					ci_q <= ci_q + mqdh_pkg::FW'(1);
				end
			end
			mqdh_pkg::S_DDEC: begin
				if (!stop_dn) begin
					hole_q <= bidx_q;
				end
			end
			mqdh_pkg::S_INS: begin
				hole_q <= mqdh_pkg::POS_W'(fill_rd);
				if (fill_rd >= mqdh_pkg::FW'(mqdh_pkg::HEAP_CAPACITY)) begin
					rs_q <= mqdh_pkg::ST_FULL;
				end
			end
			mqdh_pkg::S_UWAIT: begin
				if (swap_up) begin
					hole_q <= parent;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status       <= rs_q;
			out_task     <= rt_q;
			out_priority <= rp_q;
		end
	end
endmodule

@@ hdl/multiqueue_dary_heap_scheduler_unit.sv @@
// Top level of the multiqueue d-ary heap scheduler: config register, front, back.
// Depends on mqdh_pkg, mqdh_front, mqdh_back.
//
// channel | handshake            | words
// in      | in_valid / in_stall  | func, heap_a, heap_b, task_handle, priority_req
// out     | out_valid / out_stall| status, out_task, out_priority
// cfg     | APB psel/penable     | heap_count at byte address 0
//
// Errors, the unused code and queries read no slot memory; insert climbs level by level
// and delete descends level by level, reading each child of a level in turn.
// The single-port slot memory reads one slot per cycle and so bounds insert and delete.
// Reset empties all heaps (fill counts and cached tops); slot memory is not cleared.
// A two-entry queue lets the front take words while the engine works or out stalls.
module multiqueue_dary_heap_scheduler_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         heap_a,
	input  logic [3:0]         heap_b,
	input  logic [15:0]        task_handle,
	input  logic signed [15:0] priority_req,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [15:0]        out_task,
	output logic signed [15:0] out_priority,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic [mqdh_pkg::CFG_W-1:0] heap_count_q;
	logic                       cmd_valid, cmd_pop;
	mqdh_pkg::cmd_t             cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == mqdh_pkg::REG_HEAP_COUNT) ? 32'(heap_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_count_q <= mqdh_pkg::CFG_W'(mqdh_pkg::NUM_HEAPS);
		end else if (psel && penable && pwrite && pready &&
			paddr == mqdh_pkg::REG_HEAP_COUNT) begin
			heap_count_q <= pwdata[mqdh_pkg::CFG_W-1:0];
		end
	end

	mqdh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.heap_count   (heap_count_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.heap_a       (heap_a),
		.heap_b       (heap_b),
		.task_handle  (task_handle),
		.priority_req (priority_req),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	mqdh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_task     (out_task),
		.out_priority (out_priority)
	);
endmodule

@@ hdl/mqdh_checker.sv @@
// Port-level checks for the heap scheduler, bound to the top level.
// Depends on mqdh_pkg and multiqueue_dary_heap_scheduler_unit.
module mqdh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic [15:0]        out_task,
	input logic signed [15:0] out_priority
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("out_valid dropped");
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(out_task)
		&& $stable(out_priority)) else $error("stalled word changed");
	a_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mqdh_pkg::ST_OK |-> out_task == 16'd0)
		else $error("task on failed op");
	a_empty_prio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mqdh_pkg::ST_EMPTY |-> out_priority == mqdh_pkg::EMPTY_PRIO)
		else $error("empty priority");
	a_range_prio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mqdh_pkg::ST_RANGE || status == mqdh_pkg::ST_FULL)
		|-> out_priority == 16'sd0) else $error("priority on error");
endmodule

bind multiqueue_dary_heap_scheduler_unit mqdh_checker u_mqdh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.out_task     (out_task),
	.out_priority (out_priority)
);
